### hdl/mbi_pkg.sv
// Package for the MurmurHash2 bucket index block: constants and sequencer state type.
// No dependencies; imported by murmur2_bucket_index.
package mbi_pkg;

  localparam logic [31:0] MUR_MUL        = 32'h5bd1_e995;
  localparam int          MUR_SHIFT      = 24;
  localparam int          FIN_SHIFT_A    = 13;
  localparam int          FIN_SHIFT_B    = 15;
  localparam int          HASH_W         = 32;
  localparam int          TSIZE_W        = 17;
  localparam int          LEN_W          = 16;
  localparam int          IDX_W          = 16;
  localparam int          DIV_CNT_W      = 5;
  localparam logic [TSIZE_W-1:0] TSIZE_RST = 17'd1024;

  typedef enum logic [2:0] {
    S_IDLE,
    S_K1,
    S_K2,
    S_HMIX,
    S_TAIL,
    S_FIN,
    S_DIV,
    S_DONE
  } mbi_state_t;

endpackage

### hdl/murmur2_bucket_index.sv
// Streaming 32-bit MurmurHash2 (seed 0) with reduction modulo a table size.
// Depends on mbi_pkg for constants and the sequencer state type.
//
// Usage:
//   Input channel (in_*): one key word per transfer, little-endian, with the
//   count of valid bytes and a last-word flag. in_key_length is sampled on the
//   first word of each key only. Byte counts above four count as four.
//   Output channel (out_*): one result per key, issued after its last word:
//   the finalised hash and hash modulo table size cut to 16 bits (0 when the size is zero).
//   cfg_wr_en/cfg_wr_data write the 17-bit table size (reset 1024); write it
//   only while no key is in flight.
// Sequencing (one shared 32x32 multiplier, one restoring-divide step per cycle):
//   full word     : states K1, K2, HMIX, then back to idle for the next transfer
//   1..3 byte word: state TAIL;  zero-byte word: no mixing state
//   last word     : then finalise (FIN), divide (DIV) and hand-off (DONE)
//   The remainder loop, 32 iterations of one 18-bit compare/subtract, sets
//   the tail latency. in_stall is high whenever the sequencer is busy.
// Output stage: a result register holds the finished result; while it waits
// under out_stall the next key is still taken and hashed, and only the
// hand-off of the next result waits for the register to free.
// Reset (synchronous, active low) empties the output register, clears the
// accumulator, arms the first-word flag and restores the table size.
module murmur2_bucket_index
  import mbi_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration
  input  logic               cfg_wr_en,
  input  logic [TSIZE_W-1:0] cfg_wr_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [HASH_W-1:0]  in_key_word,
  input  logic [2:0]         in_bytes_in_word,
  input  logic               in_last_word,
  input  logic [LEN_W-1:0]   in_key_length,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [HASH_W-1:0]  out_hash_value,
  output logic [IDX_W-1:0]   out_bucket_index
);

  mbi_state_t state_r, state_nxt;

  logic [TSIZE_W-1:0]   table_size_r;
  logic                 first_r, first_nxt;     // next word opens a new key
  logic [HASH_W-1:0]    h_r, h_nxt;             // running hash / final hash
  logic [HASH_W-1:0]    k_r, k_nxt;             // word being mixed
  logic                 last_r, last_nxt;
  logic [HASH_W-1:0]    div_r, div_nxt;         // dividend, shifted out MSB first
  logic [TSIZE_W-1:0]   rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [HASH_W-1:0]    out_hash_r, out_hash_nxt;
  logic [IDX_W-1:0]     out_idx_r, out_idx_nxt;

  // shared multiplier: low 32 bits of operand * MUR_MUL
  logic [HASH_W-1:0]    mul_a;
  logic [HASH_W-1:0]    mul_p;
  logic [HASH_W-1:0]    fin_h;
  logic [TSIZE_W:0]     div_trial;
  logic [TSIZE_W:0]     div_diff;
  logic                 div_ge;
  logic [HASH_W-1:0]    tail_mask;
  logic [HASH_W-1:0]    h_base;
  logic                 in_xfer;
  logic                 out_xfer;
  logic                 out_free;

  assign mul_p = mul_a * MUR_MUL;
  assign fin_h = mul_p ^ (mul_p >> FIN_SHIFT_B);

  // one restoring-divide step
  assign div_trial = {rem_r, div_r[HASH_W-1]};
  assign div_diff  = div_trial - {1'b0, table_size_r};
  assign div_ge    = (div_trial >= {1'b0, table_size_r});

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_free  = !out_valid_r || !out_stall;

  assign h_base = first_r ? {{(HASH_W-LEN_W){1'b0}}, in_key_length} : h_r;

  always_comb begin
    case (in_bytes_in_word[1:0])
      2'd1:    tail_mask = 32'h0000_00ff;
      2'd2:    tail_mask = 32'h0000_ffff;
      2'd3:    tail_mask = 32'h00ff_ffff;
      default: tail_mask = 32'h0000_0000;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      table_size_r <= TSIZE_RST;
      first_r      <= 1'b1;
      h_r          <= '0;
      out_valid_r  <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      first_r      <= first_nxt;
      h_r          <= h_nxt;
      out_valid_r  <= out_valid_nxt;
      cnt_r        <= cnt_nxt;
      if (cfg_wr_en) begin
        table_size_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    last_r     <= last_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    out_hash_r <= out_hash_nxt;
    out_idx_r  <= out_idx_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    h_nxt         = h_r;
    k_nxt         = k_r;
    last_nxt      = last_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    out_hash_nxt  = out_hash_r;
    out_idx_nxt   = out_idx_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    mul_a         = h_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          first_nxt = 1'b0;
          h_nxt     = h_base;
          last_nxt  = in_last_word;
          if (in_bytes_in_word[2]) begin
            k_nxt     = in_key_word;
            state_nxt = S_K1;
          end else if (in_bytes_in_word[1:0] != 2'd0) begin
            k_nxt     = in_key_word & tail_mask;
            state_nxt = S_TAIL;
          end else begin
            state_nxt = in_last_word ? S_FIN : S_IDLE;
          end
        end
      end
      S_K1: begin
        mul_a     = k_r;
        k_nxt     = mul_p;
        state_nxt = S_K2;
      end
      S_K2: begin
        mul_a     = k_r ^ (k_r >> MUR_SHIFT);
        k_nxt     = mul_p;
        state_nxt = S_HMIX;
      end
      S_HMIX: begin
        mul_a     = h_r;
        h_nxt     = mul_p ^ k_r;
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_TAIL: begin
        mul_a     = h_r ^ k_r;
        h_nxt     = mul_p;
        state_nxt = last_r ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        mul_a     = h_r ^ (h_r >> FIN_SHIFT_A);
        h_nxt     = fin_h;
        div_nxt   = fin_h;
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt = div_ge ? div_diff[TSIZE_W-1:0] : div_trial[TSIZE_W-1:0];
        div_nxt = {div_r[HASH_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == {DIV_CNT_W{1'b1}}) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait here only if the previous result is still held
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = h_r;
          out_idx_nxt   = (table_size_r == '0) ? '0 : rem_r[IDX_W-1:0];
          h_nxt         = '0;
          first_nxt     = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_hash_value   = out_hash_r;
  assign out_bucket_index = out_idx_r;

endmodule

### sim/murmur2_bucket_index_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for murmur2_bucket_index: streams keys, predicts each hash and bucket.
// Depends on mbi_pkg (port widths) and the murmur2_bucket_index RTL only.
module murmur2_bucket_index_tb;
  import mbi_pkg::*;

  // Hash constants, kept locally so the predictor stands apart from the RTL
  localparam logic [31:0] MULT      = 32'h5bd1_e995;
  localparam int          MIX_SH    = 24;
  localparam int          FOLD_SH_A = 13;
  localparam int          FOLD_SH_B = 15;

  // Drain pause before a register write, end wait and stall watchdog
  localparam int SETTLE_CYCLES  = 60;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [HASH_W-1:0] word;
    logic [2:0]        nbytes;
    logic              last;
    logic [LEN_W-1:0]  klen;
  } key_word_t;

  typedef struct {
    logic [HASH_W-1:0] hash;
    logic [IDX_W-1:0]  bucket;
  } bucket_result_t;

  logic               clk;
  logic               rst_n       = 1'b0;
  logic               cfg_wr_en   = 1'b0;
  logic [TSIZE_W-1:0] cfg_wr_data = '0;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic [HASH_W-1:0]  in_key_word      = '0;
  logic [2:0]         in_bytes_in_word = '0;
  logic               in_last_word     = 1'b0;
  logic [LEN_W-1:0]   in_key_length    = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [HASH_W-1:0]  out_hash_value;
  logic [IDX_W-1:0]   out_bucket_index;

  murmur2_bucket_index i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_key_word      (in_key_word),
    .in_bytes_in_word (in_bytes_in_word),
    .in_last_word     (in_last_word),
    .in_key_length    (in_key_length),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hash_value   (out_hash_value),
    .out_bucket_index (out_bucket_index)
  );

  // Words waiting to be driven, and results owed by the block, oldest first
  key_word_t      pending_words[$];
  bucket_result_t owed_results[$];

  // Shadow of the block: running hash, start-of-key flag, table size
  logic [31:0]        hash_acc     = '0;
  bit                 new_key      = 1'b1;
  logic [TSIZE_W-1:0] tsize_shadow = TSIZE_RST;

  bit          idle_on   = 1'b1;   // random idling on both sides
  bit          in_taken  = 1'b0;   // input transfer at the last rising edge
  int unsigned send_gap  = 0;
  int unsigned stall_left = 0;
  int unsigned words_queued = 0;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;

  key_word_t      drive_word;
  bucket_result_t predicted;
  bucket_result_t oldest;
  logic [2:0]     lane_count;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // One full little-endian word folded into the running hash
  function automatic logic [31:0] mix_key_word(logic [31:0] acc, logic [31:0] k);
    k = k * MULT;
    k = k ^ (k >> MIX_SH);
    k = k * MULT;
    acc = acc * MULT;
    return acc ^ k;
  endfunction

  // Cascading tail: byte 2, then byte 1, then byte 0 and the multiply
  function automatic logic [31:0] fold_tail_bytes(logic [31:0] acc, logic [31:0] w,
                                                  logic [2:0] n);
    if (n >= 3'd3) acc = acc ^ {8'h00, w[23:16], 16'h0000};
    if (n >= 3'd2) acc = acc ^ {16'h0000, w[15:8], 8'h00};
    if (n >= 3'd1) begin
      acc = acc ^ {24'h000000, w[7:0]};
      acc = acc * MULT;
    end
    return acc;
  endfunction

  function automatic bucket_result_t finalise_key(logic [31:0] acc,
                                                  logic [TSIZE_W-1:0] tsize);
    bucket_result_t r;
    logic [31:0]    h;
    logic [31:0]    rem;
    h = acc ^ (acc >> FOLD_SH_A);
    h = h * MULT;
    h = h ^ (h >> FOLD_SH_B);
    // zero-sized table maps everything to bucket 0; oversized tables are truncated
    rem = (tsize != '0) ? (h % {15'd0, tsize}) : 32'd0;
    r.hash   = h;
    r.bucket = rem[IDX_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Driver: input changes on the falling edge, one word per transfer.
  // A payload stays put until its transfer; gaps only open after a transfer.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_words.size() > 0) begin
        drive_word = pending_words.pop_front();
        in_key_word      <= drive_word.word;
        in_bytes_in_word <= drive_word.nbytes;
        in_last_word     <= drive_word.last;
        in_key_length    <= drive_word.klen;
        in_valid         <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 8);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: random stall bursts while idling is on
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 8) - 1;
        out_stall  <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled on the rising edge.
  // Results are checked before the word of this edge is predicted; a result
  // can never come out in the cycle its last word goes in.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      in_taken = in_valid && !in_stall;

      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with none owed: hash %h bucket %0d",
                     $realtime, out_hash_value, out_bucket_index);
        end else begin
          oldest = owed_results.pop_front();
          if (out_hash_value !== oldest.hash || out_bucket_index !== oldest.bucket) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: hash exp %h got %h, bucket exp %0d got %0d",
                       $realtime, oldest.hash, out_hash_value,
                       oldest.bucket, out_bucket_index);
          end
        end
      end

      if (in_taken) begin
        // key length only counts on the first word of a key
        if (new_key) begin
          hash_acc = {{(32-LEN_W){1'b0}}, in_key_length};
          new_key  = 1'b0;
        end
        lane_count = (in_bytes_in_word > 3'd4) ? 3'd4 : in_bytes_in_word;
        if (lane_count == 3'd4) hash_acc = mix_key_word(hash_acc, in_key_word);
        else                    hash_acc = fold_tail_bytes(hash_acc, in_key_word, lane_count);
        if (in_last_word) begin
          predicted = finalise_key(hash_acc, tsize_shadow);
          owed_results.push_back(predicted);
          hash_acc = '0;
          new_key  = 1'b1;
        end
      end

      // watchdog: cycles with no transfer on either channel
      if (in_taken || (out_valid && !out_stall) || cfg_wr_en) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results owed",
                 $realtime, quiet_cycles, owed_results.size());
        $display("** murmur2_bucket_index: FAILED **");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_word(logic [31:0] w, logic [2:0] n, logic last, logic [15:0] klen);
    key_word_t kw;
    kw.word   = w;
    kw.nbytes = n;
    kw.last   = last;
    kw.klen   = klen;
    pending_words.push_back(kw);
    words_queued++;
  endtask

  // Sender holds off until every word is in and every result is out
  task automatic wait_drained();
    do @(posedge clk);
    while (pending_words.size() != 0 || in_valid || owed_results.size() != 0);
  endtask

  // Register writes happen only here, with the block drained and settled
  task automatic run_phase(logic [TSIZE_W-1:0] tsize, bit idling, int unsigned n_words);
    int unsigned target;
    int unsigned pick;
    int unsigned key_bytes;
    int unsigned nw;
    int unsigned rem;
    logic [15:0] klen;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tsize;
    @(negedge clk);
    cfg_wr_en    <= 1'b0;
    tsize_shadow = tsize;
    idle_on      = idling;

    target = words_queued + n_words;
    while (words_queued < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // noise: any byte count on any word, short words mid-key, random length
        nw = $urandom_range(1, 6);
        for (int i = 0; i < nw; i++)
          push_word($urandom, 3'($urandom_range(0, 7)), i == nw - 1, 16'($urandom));
      end else begin
        // well-formed key: full words, tail bytes on the last one
        key_bytes = (pick < 19) ? $urandom_range(64, 256) : $urandom_range(0, 16);
        klen      = (pick >= 90) ? 16'($urandom) : 16'(key_bytes);
        rem = key_bytes;
        do begin
          nw  = (rem >= 4) ? 4 : rem;
          rem = rem - nw;
          push_word($urandom, 3'(nw), rem == 0, klen);
          klen = 16'($urandom);   // ignored past the first word
        end while (rem != 0);
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed keys at the reset table size
    push_word(32'h1234_5678, 3'd0, 1'b1, 16'd0);        // empty key
    push_word(32'hFFFF_FFFF, 3'd1, 1'b1, 16'd1);        // one byte, dirty upper lanes
    push_word(32'hA5A5_A5A5, 3'd2, 1'b1, 16'd2);
    push_word(32'hFFFF_FFFF, 3'd3, 1'b1, 16'd3);
    push_word(32'hFFFF_FFFF, 3'd4, 1'b1, 16'd4);        // full word marked last
    push_word(32'h0000_0000, 3'd4, 1'b1, 16'd4);
    push_word(32'hDEAD_BEEF, 3'd4, 1'b0, 16'd5);        // five bytes
    push_word(32'hFFFF_FFAB, 3'd1, 1'b1, 16'd0);
    push_word(32'h0BAD_F00D, 3'd5, 1'b1, 16'd4);        // counts above four
    push_word(32'hFFFF_FFFF, 3'd6, 1'b1, 16'd4);
    push_word(32'h8000_0001, 3'd7, 1'b1, 16'd4);
    push_word(32'h00C0_FFEE, 3'd2, 1'b0, 16'd6);        // short word mid-key
    push_word(32'hFFFF_FFFF, 3'd0, 1'b0, 16'd0);        // zero-byte word mid-key
    push_word(32'h7654_3210, 3'd4, 1'b1, 16'hFFFF);
    push_word(32'hFFFF_FFFF, 3'd4, 1'b1, 16'hFFFF);     // length far off the bytes sent
    push_word(32'h0000_0000, 3'd0, 1'b1, 16'hFFFF);
    push_word(32'h5555_AAAA, 3'd3, 1'b0, 16'h8000);
    push_word(32'hAAAA_5555, 3'd3, 1'b0, 16'h0000);
    push_word(32'h0F0F_F0F0, 3'd3, 1'b1, 16'h0001);

    // Table sizes: extremes first, then random, ending at the reset value
    run_phase(17'd1,       1'b1, 150);
    run_phase(17'd65536,   1'b1, 200);
    run_phase(17'd0,       1'b1, 100);
    run_phase(17'h1FFFF,   1'b1, 150);
    run_phase(17'($urandom_range(1, 65536)), 1'b1, 200);
    run_phase(17'($urandom_range(1, 64)),    1'b0, 200);
    run_phase(17'($urandom_range(1, 65536)), 1'b1, 200);
    run_phase(17'($urandom_range(2, 1000)),  1'b1, 200);
    run_phase(TSIZE_RST,   1'b0, 250);                  // closing stretch, no idling

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("** murmur2_bucket_index: PASSED **");
    end else begin
      $display("%0d failures, %0d results still owed", fail_count, owed_results.size());
      $display("** murmur2_bucket_index: FAILED **");
    end
    $finish;
  end

endmodule
